FILE: rtl/c2s_pkg.sv
// c2s_pkg: shared types, widths and constants of the Cartesian to spherical converter.
// Used by c2s_cell, c2s_pass and cartesian_to_spherical. No dependencies.
package c2s_pkg;

  // Field widths and iteration count
  localparam int COORD_BITS   = 24;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD        = 8;

  // Datapath: scaled coordinate plus growth headroom of the vectoring passes
  localparam int DATA_W = 36;
  // Magnitude out of a pass (radius with guard bits reaches about 2^33)
  localparam int MAG_W  = 34;
  // Angle accumulator, Q32 turns
  localparam int ACC_W  = 32;
  // Side payload carried alongside a pass
  localparam int SIDE_W = COORD_BITS;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  // Inverse CORDIC gain for 16 iterations, Q30
  localparam int K_W       = 30;
  localparam int GAIN_FRAC = 30;
  localparam logic [K_W-1:0] INV_GAIN = 30'd652032874;

  // Gain multiply is split into two narrow partial products
  localparam int MUL_SPLIT = 17;
  localparam int PROD_W    = MAG_W - MUL_SPLIT + K_W;
  localparam int SUM_W     = PROD_W + MUL_SPLIT;
  localparam logic [SUM_W-1:0] GAIN_RND = SUM_W'(1) << (GAIN_FRAC - 1);

  localparam logic [ACC_W-1:0] HALF_TURN    = ACC_W'(1) << (ACC_W - 1);
  localparam logic [ACC_W-1:0] QUARTER_TURN = ACC_W'(1) << (ACC_W - 2);
  localparam logic [ACC_W-1:0] NEG_QUARTER  = HALF_TURN + QUARTER_TURN;
  localparam logic [ACC_W-1:0] ANGLE_RND    = ACC_W'(1) << (ACC_W - ANGLE_BITS - 1);
  localparam logic [MAG_W:0]   RADIUS_RND   = (MAG_W + 1)'(1) << (GUARD - 1);

  // atan(2^-i) in Q32 turns, rounded to nearest
  localparam logic [ACC_W-1:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Item on the input channel
  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
  } c2s_in_t;

  // Item on the result channel
  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] azimuth;
    logic signed [ANGLE_BITS-1:0] elevation;
    logic [COORD_BITS-1:0]        radius;
  } c2s_out_t;

  // Operand pair entering a vectoring pass
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [SIDE_W-1:0]        side;
  } c2s_pair_t;

  // State handed from cell to cell
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [ACC_W-1:0]         ang;
    logic                     bypass;
    logic [SIDE_W-1:0]        side;
  } c2s_stage_t;

  // Gain correction partial products
  typedef struct packed {
    logic [PROD_W-1:0] p_hi;
    logic [PROD_W-1:0] p_lo;
    logic [MAG_W-1:0]  mag;
    logic              bypass;
    logic [ACC_W-1:0]  ang;
    logic [SIDE_W-1:0] side;
  } c2s_gain_t;

  // Result of a vectoring pass
  typedef struct packed {
    logic [ACC_W-1:0]  ang;
    logic [MAG_W-1:0]  mag;
    logic [SIDE_W-1:0] side;
  } c2s_polar_t;

  // Coordinate times 2^GUARD, sign extended to the datapath
  function automatic logic signed [DATA_W-1:0] scale_coord(logic [COORD_BITS-1:0] v);
    return {{(DATA_W - COORD_BITS - GUARD){v[COORD_BITS-1]}}, v, {GUARD{1'b0}}};
  endfunction

  // Round Q32 turns to the output angle width, wrapping around the circle
  function automatic logic [ANGLE_BITS-1:0] angle_round(logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] sum;
    sum = acc + ANGLE_RND;
    return sum[ACC_W-1:ACC_W-ANGLE_BITS];
  endfunction

endpackage

FILE: rtl/c2s_cell.sv
// c2s_cell: one CORDIC vectoring iteration with its pipeline register.
// Depends on c2s_pkg.
module c2s_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  c2s_pkg::c2s_stage_t         in_data,
  input  logic [c2s_pkg::STEP_W-1:0]  shift,
  input  logic [c2s_pkg::ACC_W-1:0]   step_angle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output c2s_pkg::c2s_stage_t         out_data
);

  logic                             valid_r;
  c2s_pkg::c2s_stage_t              data_r;
  c2s_pkg::c2s_stage_t              data_nxt;
  logic signed [c2s_pkg::DATA_W-1:0] a_sh;
  logic signed [c2s_pkg::DATA_W-1:0] b_sh;
  logic                             b_pos;

  assign a_sh  = $signed(in_data.a) >>> shift;
  assign b_sh  = $signed(in_data.b) >>> shift;
  assign b_pos = !in_data.b[c2s_pkg::DATA_W-1] && (in_data.b != '0);

  // Rotate toward the x axis; special-case items pass through untouched
  always_comb begin
    data_nxt = in_data;
    if (!in_data.bypass) begin
      if (b_pos) begin
        data_nxt.a   = in_data.a + b_sh;
        data_nxt.b   = in_data.b - a_sh;
        data_nxt.ang = in_data.ang + step_angle;
      end else begin
        data_nxt.a   = in_data.a - b_sh;
        data_nxt.b   = in_data.b + a_sh;
        data_nxt.ang = in_data.ang - step_angle;
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/c2s_pass.sv
// c2s_pass: one vectoring pass: special-case stage, chain of CORDIC cells,
// two-stage gain correction. Depends on c2s_pkg and c2s_cell.
module c2s_pass (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  c2s_pkg::c2s_pair_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output c2s_pkg::c2s_polar_t  out_data
);

  localparam int N = c2s_pkg::CORDIC_STEPS;

  logic                 prep_valid_r;
  c2s_pkg::c2s_stage_t  prep_r;
  c2s_pkg::c2s_stage_t  prep_nxt;
  logic                 prep_ready;
  logic                 a_neg;
  logic                 b_neg;
  logic                 a_zero;
  logic                 b_zero;

  logic                 chain_valid [N+1];
  logic                 chain_ready [N+1];
  c2s_pkg::c2s_stage_t  chain_data  [N+1];

  logic                 g1_valid_r;
  c2s_pkg::c2s_gain_t   g1_r;
  c2s_pkg::c2s_gain_t   g1_nxt;
  logic                 g1_ready;
  logic [c2s_pkg::MAG_W-1:0] mag_in;

  logic                 out_valid_r;
  c2s_pkg::c2s_polar_t  out_r;
  c2s_pkg::c2s_polar_t  out_nxt;
  logic                 g2_ready;
  logic [c2s_pkg::SUM_W-1:0] gain_sum;

  // Special cases: an axis-aligned pair skips the iterations
  assign a_neg  = in_data.a[c2s_pkg::DATA_W-1];
  assign b_neg  = in_data.b[c2s_pkg::DATA_W-1];
  assign a_zero = (in_data.a == '0);
  assign b_zero = (in_data.b == '0);

  always_comb begin
    prep_nxt        = '0;
    prep_nxt.side   = in_data.side;
    priority if (b_zero) begin
      prep_nxt.bypass = 1'b1;
      prep_nxt.a      = a_neg ? -in_data.a : in_data.a;
      prep_nxt.ang    = a_neg ? c2s_pkg::HALF_TURN : '0;
    end else if (a_zero) begin
      prep_nxt.bypass = 1'b1;
      prep_nxt.a      = b_neg ? -in_data.b : in_data.b;
      prep_nxt.ang    = b_neg ? c2s_pkg::NEG_QUARTER : c2s_pkg::QUARTER_TURN;
    end else if (a_neg) begin
      // left half plane: mirror through the origin, start at a half turn
      prep_nxt.a   = -in_data.a;
      prep_nxt.b   = -in_data.b;
      prep_nxt.ang = c2s_pkg::HALF_TURN;
    end else begin
      prep_nxt.a   = in_data.a;
      prep_nxt.b   = in_data.b;
    end
  end

  assign prep_ready = !prep_valid_r || chain_ready[0];
  assign in_ready   = prep_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (prep_ready) begin
      prep_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && prep_ready) begin
      prep_r <= prep_nxt;
    end
  end

  assign chain_valid[0] = prep_valid_r;
  assign chain_data[0]  = prep_r;

  // Row of iteration cells, one per CORDIC step
  for (genvar i = 0; i < N; i++) begin : g_cell
    c2s_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (chain_valid[i]),
      .in_ready   (chain_ready[i]),
      .in_data    (chain_data[i]),
      .shift      (c2s_pkg::STEP_W'(i)),
      .step_angle (c2s_pkg::ATAN_TURNS[i]),
      .out_valid  (chain_valid[i+1]),
      .out_ready  (chain_ready[i+1]),
      .out_data   (chain_data[i+1])
    );
  end

  // Gain stage 1: two partial products of magnitude times inverse gain
  assign mag_in = chain_data[N].a[c2s_pkg::MAG_W-1:0];

  always_comb begin
    g1_nxt.p_hi   = c2s_pkg::PROD_W'(mag_in[c2s_pkg::MAG_W-1:c2s_pkg::MUL_SPLIT])
                    * c2s_pkg::PROD_W'(c2s_pkg::INV_GAIN);
    g1_nxt.p_lo   = c2s_pkg::PROD_W'(mag_in[c2s_pkg::MUL_SPLIT-1:0])
                    * c2s_pkg::PROD_W'(c2s_pkg::INV_GAIN);
    g1_nxt.mag    = mag_in;
    g1_nxt.bypass = chain_data[N].bypass;
    g1_nxt.ang    = chain_data[N].ang;
    g1_nxt.side   = chain_data[N].side;
  end

  assign g1_ready       = !g1_valid_r || g2_ready;
  assign chain_ready[N] = g1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_valid_r <= 1'b0;
    end else if (g1_ready) begin
      g1_valid_r <= chain_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[N] && g1_ready) begin
      g1_r <= g1_nxt;
    end
  end

  // Gain stage 2: sum partial products, round to nearest (half up)
  assign gain_sum = {g1_r.p_hi, {c2s_pkg::MUL_SPLIT{1'b0}}}
                    + c2s_pkg::SUM_W'(g1_r.p_lo) + c2s_pkg::GAIN_RND;

  always_comb begin
    out_nxt.ang  = g1_r.ang;
    out_nxt.side = g1_r.side;
    out_nxt.mag  = g1_r.bypass ? g1_r.mag
                 : gain_sum[c2s_pkg::GAIN_FRAC+c2s_pkg::MAG_W-1:c2s_pkg::GAIN_FRAC];
  end

  assign g2_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (g2_ready) begin
      out_valid_r <= g1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (g1_valid_r && g2_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/cartesian_to_spherical.sv
// cartesian_to_spherical: (x, y, z) to azimuth, elevation, radius by two CORDIC passes.
// Each pass registers its special-case stage, its cells and its gain stages; one output
// register follows. Throughput: one item per cycle while the output is not stalled;
// every cell stage holds an item, bubbles close up when the output is stalled. Reset
// (rst_n low, synchronous) empties the pipeline. Depends on c2s_pkg and c2s_pass.
module cartesian_to_spherical (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  c2s_pkg::c2s_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output c2s_pkg::c2s_out_t  out_data
);

  c2s_pkg::c2s_pair_t   p1_in;
  logic                 p1_in_ready;
  logic                 p1_valid;
  c2s_pkg::c2s_polar_t  p1_out;
  c2s_pkg::c2s_pair_t   p2_in;
  logic                 p2_in_ready;
  logic                 p2_valid;
  c2s_pkg::c2s_polar_t  p2_out;
  logic                 p2_ready;

  logic                 out_valid_r;
  c2s_pkg::c2s_out_t    out_r;
  c2s_pkg::c2s_out_t    out_nxt;
  logic [c2s_pkg::MAG_W:0]               rad_sum;
  logic [c2s_pkg::MAG_W-c2s_pkg::GUARD:0] rad_full;

  // Pass 1 on (x, y); z rides along
  assign p1_in.a    = c2s_pkg::scale_coord(in_data.coord_x);
  assign p1_in.b    = c2s_pkg::scale_coord(in_data.coord_y);
  assign p1_in.side = in_data.coord_z;
  assign in_stall   = !p1_in_ready;

  c2s_pass u_pass_az (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (p1_in_ready),
    .in_data   (p1_in),
    .out_valid (p1_valid),
    .out_ready (p2_in_ready),
    .out_data  (p1_out)
  );

  // Pass 2 on (planar magnitude, z); the azimuth rides along
  assign p2_in.a    = c2s_pkg::DATA_W'(p1_out.mag);
  assign p2_in.b    = c2s_pkg::scale_coord(p1_out.side);
  assign p2_in.side = c2s_pkg::SIDE_W'(c2s_pkg::angle_round(p1_out.ang));

  c2s_pass u_pass_el (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p1_valid),
    .in_ready  (p2_in_ready),
    .in_data   (p2_in),
    .out_valid (p2_valid),
    .out_ready (p2_ready),
    .out_data  (p2_out)
  );

  // Radius: drop guard bits with rounding, then saturate
  assign rad_sum  = {1'b0, p2_out.mag} + c2s_pkg::RADIUS_RND;
  assign rad_full = rad_sum[c2s_pkg::MAG_W:c2s_pkg::GUARD];

  always_comb begin
    out_nxt.azimuth   = p2_out.side[c2s_pkg::ANGLE_BITS-1:0];
    out_nxt.elevation = c2s_pkg::angle_round(p2_out.ang);
    if (rad_full[c2s_pkg::MAG_W-c2s_pkg::GUARD:c2s_pkg::COORD_BITS] != '0) begin
      out_nxt.radius = '1;
    end else begin
      out_nxt.radius = rad_full[c2s_pkg::COORD_BITS-1:0];
    end
  end

  // Output register
  assign p2_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p2_ready) begin
      out_valid_r <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_valid && p2_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Input is refused only when every stage is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the pipeline could still move");

  // Elevation stays within plus or minus a quarter turn
  a_elevation_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.elevation) <= $signed(16'sd16384)
                   && $signed(out_data.elevation) >= $signed(-16'sd16384)))
    else $error("elevation outside a quarter turn");

endmodule
